>>> rtl/dhcp_option_tlv_parser_top_macros.svh
// Assertion macros for the options parser.
`ifndef DHCP_OPTION_TLV_PARSER_TOP_MACROS_SVH
`define DHCP_OPTION_TLV_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/dhcp_tlv_pkg.sv
package dhcp_tlv_pkg;

	// Option codes with a meaning of their own.
	localparam logic [7:0] PAD_CODE  = 8'd0;
	localparam logic [7:0] END_CODE  = 8'hff;
	localparam logic [7:0] TYPE_CODE = 8'd53;
	localparam logic [7:0] ADDR_CODE = 8'd50;

	// Values of the message type option that are recognized.
	localparam logic [7:0] TYPE_DISCOVER = 8'd1;
	localparam logic [7:0] TYPE_OFFER    = 8'd2;
	localparam logic [7:0] TYPE_REQUEST  = 8'd3;
	localparam logic [7:0] TYPE_ACK      = 8'd5;

	// Number of option codes that the seen map covers.
	localparam int CODE_SPACE = 256;

	// Number of leading value bytes of the address option that are kept.
	localparam logic [2:0] ADDR_BYTES = 3'd4;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 56;

	typedef enum logic [2:0] {
		CLASS_VENDOR   = 3'd0,
		CLASS_DISCOVER = 3'd1,
		CLASS_OFFER    = 3'd2,
		CLASS_REQUEST  = 3'd3,
		CLASS_ACK      = 3'd4,
		CLASS_UNKNOWN  = 3'd5
	} msg_class_t;

	function automatic msg_class_t classify(input logic [7:0] t);
		msg_class_t c;
		unique case (t)
			TYPE_DISCOVER: c = CLASS_DISCOVER;
			TYPE_OFFER:    c = CLASS_OFFER;
			TYPE_REQUEST:  c = CLASS_REQUEST;
			TYPE_ACK:      c = CLASS_ACK;
			default:       c = CLASS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/dhcp_option_tlv_parser_top.sv
// Options-area parser for DHCP and vendor-specific option lists.
// The slave channel takes one byte of the options area per transaction on s_tdata;
// s_tuser marks the first byte of a new packet, which clears the per-packet state
// (seen-code map, count, message type and requested address) before it is parsed.
// Pad codes are skipped, and each option's code, length and value bytes are walked.
// When the end code arrives in code position, one transaction leaves on the master
// channel with the message class, distinct option count, raw type byte, and the
// requested address with its valid flag. Bytes after the end code give nothing
// until the next start marker. Every other byte gives no output transaction.
// Throughput is one byte per cycle unless the receiver stalls: the byte sits in an
// input register, and one short pass of phase logic plus a single seen-map lookup
// updates the state and the result register. An accepted end code passes through
// the input register, then the result register, before it shows on m_tvalid.
// When the receiver stalls with a result waiting, the input register still takes
// a byte, then s_tready drops until the result is taken; no byte is lost.
// Reset (arst_n low) clears the parse state and empties both registers, so a
// stream that starts without a start marker is parsed from cleared state.
`include "dhcp_option_tlv_parser_top_macros.svh"

module dhcp_option_tlv_parser_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dhcp_tlv_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic [0:0]                         s_tuser,   // [0] start_of_options
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] message_class, [10:3] distinct_options, [18:11] dhcp_type_byte,
	// [19] address_valid, [51:20] requested_address, [55:52] zero
	output logic [dhcp_tlv_pkg::M_TDATA_W-1:0] m_tdata
);
	import dhcp_tlv_pkg::*;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Input register.
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Parse state.
	phase_t                phase_q;
	logic [7:0]            code_q;
	logic [7:0]            left_q;
	logic [2:0]            offset_q;
	logic [CODE_SPACE-1:0] seen_q;
	logic [7:0]            count_q;
	logic                  type_p_q;
	logic [7:0]            type_v_q;
	logic                  addr_p_q;
	logic [31:0]           addr_v_q;

	// Result register.
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	// The input register advances whenever the result register is free or drains.
	logic advance;
	logic process;

	// State as seen by the byte in the input register (cleared on a start marker).
	phase_t                ph_e;
	logic [7:0]            code_e;
	logic [7:0]            left_e;
	logic [2:0]            offset_e;
	logic [CODE_SPACE-1:0] seen_e;
	logic [7:0]            count_e;
	logic                  type_p_e;
	logic [7:0]            type_v_e;
	logic                  addr_p_e;
	logic [31:0]           addr_v_e;

	// Next state.
	phase_t                ph_n;
	logic [7:0]            code_n;
	logic [7:0]            left_n;
	logic [2:0]            offset_n;
	logic [CODE_SPACE-1:0] seen_n;
	logic [7:0]            count_n;
	logic                  type_p_n;
	logic [7:0]            type_v_n;
	logic                  addr_p_n;
	logic [31:0]           addr_v_n;

	logic                 emit;
	logic [M_TDATA_W-1:0] result;
	logic                 req_or_ack;
	logic                 av;
	msg_class_t           cls;
	logic [7:0]           left_dec;

	assign advance  = !out_valid_q || m_tready;
	assign process  = in_valid_s1 && advance;
	assign s_tready = !in_valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		if (start_s1) begin
			ph_e     = PH_CODE;
			code_e   = '0;
			left_e   = '0;
			offset_e = '0;
			seen_e   = '0;
			count_e  = '0;
			type_p_e = 1'b0;
			type_v_e = '0;
			addr_p_e = 1'b0;
			addr_v_e = '0;
		end else begin
			ph_e     = phase_q;
			code_e   = code_q;
			left_e   = left_q;
			offset_e = offset_q;
			seen_e   = seen_q;
			count_e  = count_q;
			type_p_e = type_p_q;
			type_v_e = type_v_q;
			addr_p_e = addr_p_q;
			addr_v_e = addr_v_q;
		end
	end

	// Result fields from the state at the end code.
	always_comb begin
		req_or_ack = type_p_e && (type_v_e == TYPE_REQUEST || type_v_e == TYPE_ACK);
		av         = req_or_ack && addr_p_e;
		cls        = type_p_e ? classify(type_v_e) : CLASS_VENDOR;
		result     = '0;
		result[2:0]   = cls;
		result[10:3]  = count_e;
		result[18:11] = type_p_e ? type_v_e : 8'd0;
		result[19]    = av;
		result[51:20] = av ? addr_v_e : 32'd0;
	end

	assign left_dec = left_e - 8'd1;

	always_comb begin
		ph_n     = ph_e;
		code_n   = code_e;
		left_n   = left_e;
		offset_n = offset_e;
		seen_n   = seen_e;
		count_n  = count_e;
		type_p_n = type_p_e;
		type_v_n = type_v_e;
		addr_p_n = addr_p_e;
		addr_v_n = addr_v_e;
		emit     = 1'b0;
		unique case (ph_e)
			PH_CODE: begin
				if (byte_s1 == END_CODE) begin
					emit = 1'b1;
					ph_n = PH_DONE;
				end else if (byte_s1 != PAD_CODE) begin
					if (!seen_e[byte_s1]) begin
						seen_n[byte_s1] = 1'b1;
						count_n         = count_e + 8'd1;
					end
					code_n = byte_s1;
					if (byte_s1 == TYPE_CODE) begin
						type_p_n = 1'b1;
						type_v_n = '0;
					end else if (byte_s1 == ADDR_CODE) begin
						addr_p_n = 1'b1;
						addr_v_n = '0;
					end
					ph_n = PH_LEN;
				end
			end
			PH_LEN: begin
				left_n   = byte_s1;
				offset_n = '0;
				ph_n     = (byte_s1 == 8'd0) ? PH_CODE : PH_VAL;
			end
			PH_VAL: begin
				if (code_e == TYPE_CODE && offset_e == 3'd0) begin
					type_v_n = byte_s1;
				end else if (code_e == ADDR_CODE && offset_e < ADDR_BYTES) begin
					// First value byte lands in the most significant lane.
					unique case (offset_e[1:0])
						2'd0:    addr_v_n[31:24] = byte_s1;
						2'd1:    addr_v_n[23:16] = byte_s1;
						2'd2:    addr_v_n[15:8]  = byte_s1;
						default: addr_v_n[7:0]   = byte_s1;
					endcase
				end
				// Only the first four offsets matter, so the counter stops there.
				if (offset_e < ADDR_BYTES) begin
					offset_n = offset_e + 3'd1;
				end
				left_n = left_dec;
				if (left_dec == 8'd0) begin
					ph_n = PH_CODE;
				end
			end
			default: begin
				// After the end code, bytes are dropped until a start marker.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			byte_s1     <= '0;
			start_s1    <= 1'b0;
			phase_q     <= PH_CODE;
			code_q      <= '0;
			left_q      <= '0;
			offset_q    <= '0;
			seen_q      <= '0;
			count_q     <= '0;
			type_p_q    <= 1'b0;
			type_v_q    <= '0;
			addr_p_q    <= 1'b0;
			addr_v_q    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				in_valid_s1 <= 1'b1;
				byte_s1     <= s_tdata;
				start_s1    <= s_tuser[0];
			end else if (process) begin
				in_valid_s1 <= 1'b0;
			end
			if (process) begin
				phase_q  <= ph_n;
				code_q   <= code_n;
				left_q   <= left_n;
				offset_q <= offset_n;
				seen_q   <= seen_n;
				count_q  <= count_n;
				type_p_q <= type_p_n;
				type_v_q <= type_v_n;
				addr_p_q <= addr_p_n;
				addr_v_q <= addr_v_n;
			end
			if (process && emit) begin
				out_valid_q <= 1'b1;
				out_data_q  <= result;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An address is only flagged for a request or an acknowledge.
	`DTP_ASSERT_IMP(a_addr_class, clk, arst_n,
		m_tvalid && m_tdata[19],
		m_tdata[2:0] == CLASS_REQUEST || m_tdata[2:0] == CLASS_ACK)

	// A result always leaves the parser in the done phase.
	`DTP_ASSERT_NXT(a_done_after_emit, clk, arst_n, process && emit, phase_q == PH_DONE)

	// The distinct-option count tracks the seen map.
	`DTP_ASSERT_IMP(a_count_map, clk, arst_n, 1'b1,
		32'(count_q) == 32'($countones(seen_q)))

	// With no result waiting the input side never stalls.
	`DTP_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

endmodule

>>> bench/dhcp_option_tlv_parser_top_tb.sv
`timescale 1ns / 1ps

// Bench for the options-area parser. Bytes are pushed through the slave channel, and a
// scoreboard follows each accepted byte with its own model of the option walk. The summary
// that every end code should produce is queued. Each transaction that leaves on the master
// channel is then compared, field by field, with the oldest queued summary.
module dhcp_option_tlv_parser_top_tb;
	import dhcp_tlv_pkg::*;

	// Where the option walk stands between two bytes.
	typedef enum logic [1:0] {
		WANT_CODE,
		WANT_LEN,
		IN_VALUE,
		PAST_END
	} walk_phase_t;

	// One summary transaction as the master channel should carry it.
	typedef struct {
		msg_class_t  cls;
		logic [7:0]  count;
		logic [7:0]  type_byte;
		logic        addr_ok;
		logic [31:0] addr;
	} option_summary_t;

	// The scoreboard keeps its own copy of the per-packet parse state. It also holds the
	// summaries that are still owed by the block.
	class option_summary_board;
		walk_phase_t     phase;
		logic [7:0]      cur_code;
		logic [7:0]      remaining;
		logic [7:0]      offset;
		bit              seen [CODE_SPACE];
		logic [7:0]      seen_total;
		logic            type_seen;
		logic [7:0]      type_byte;
		logic            addr_seen;
		logic [31:0]     addr_word;
		option_summary_t owed_summaries [$];
		int unsigned     total_expected;
		int unsigned     mismatches;

		function new();
			total_expected = 0;
			mismatches = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			phase = WANT_CODE;
			cur_code = '0;
			remaining = '0;
			offset = '0;
			foreach (seen[i]) seen[i] = 1'b0;
			seen_total = '0;
			type_seen = 1'b0;
			type_byte = '0;
			addr_seen = 1'b0;
			addr_word = '0;
		endfunction

		function msg_class_t class_of(logic [7:0] t);
			case (t)
				TYPE_DISCOVER: return CLASS_DISCOVER;
				TYPE_OFFER:    return CLASS_OFFER;
				TYPE_REQUEST:  return CLASS_REQUEST;
				TYPE_ACK:      return CLASS_ACK;
				default:       return CLASS_UNKNOWN;
			endcase
		endfunction

		function int unsigned pending();
			return owed_summaries.size();
		endfunction

		// Every mismatch is counted and printed.
		function void report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		// Follows one accepted byte through the option walk.
		function void note_byte(logic [7:0] b, logic start);
			option_summary_t s;
			logic req_like;
			if (start)
				clear_packet();
			case (phase)
				WANT_CODE: begin
					if (b == END_CODE) begin
						req_like = type_seen &&
							(type_byte == TYPE_REQUEST || type_byte == TYPE_ACK);
						s.cls = type_seen ? class_of(type_byte) : CLASS_VENDOR;
						s.count = seen_total;
						s.type_byte = type_seen ? type_byte : 8'd0;
						s.addr_ok = req_like && addr_seen;
						s.addr = s.addr_ok ? addr_word : 32'd0;
						owed_summaries.push_back(s);
						total_expected++;
						phase = PAST_END;
					end else if (b != PAD_CODE) begin
						if (!seen[b]) begin
							seen[b] = 1'b1;
							seen_total = seen_total + 8'd1;
						end
						cur_code = b;
						// A repeated type or address option starts over from a blank value.
						if (b == TYPE_CODE) begin
							type_seen = 1'b1;
							type_byte = '0;
						end else if (b == ADDR_CODE) begin
							addr_seen = 1'b1;
							addr_word = '0;
						end
						phase = WANT_LEN;
					end
				end
				WANT_LEN: begin
					remaining = b;
					offset = '0;
					phase = (b == 8'd0) ? WANT_CODE : IN_VALUE;
				end
				IN_VALUE: begin
					if (cur_code == TYPE_CODE && offset == 8'd0)
						type_byte = b;
					else if (cur_code == ADDR_CODE && offset < 8'(ADDR_BYTES))
						addr_word = addr_word | (32'(b) << (24 - 8 * offset));
					if (offset != 8'hff)
						offset = offset + 8'd1;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						phase = WANT_CODE;
				end
				default: ;
			endcase
		endfunction

		// Compares one summary transaction from the master channel with the oldest one owed.
		function void check_summary(logic [M_TDATA_W-1:0] word);
			option_summary_t want;
			if (owed_summaries.size() == 0) begin
				report("unexpected summary", 32'd0, word[31:0]);
				return;
			end
			want = owed_summaries.pop_front();
			if (word[2:0] !== want.cls)
				report("message_class", 32'(want.cls), 32'(word[2:0]));
			if (word[10:3] !== want.count)
				report("distinct_options", 32'(want.count), 32'(word[10:3]));
			if (word[18:11] !== want.type_byte)
				report("dhcp_type_byte", 32'(want.type_byte), 32'(word[18:11]));
			if (word[19] !== want.addr_ok)
				report("address_valid", 32'(want.addr_ok), 32'(word[19]));
			if (word[51:20] !== want.addr)
				report("requested_address", want.addr, word[51:20]);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	option_summary_board sb;

	// These settings are chosen again for every random packet. The source gaps and the
	// sink stalls shift between packets, and some packets see no idling at all.
	int unsigned src_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned stall_left = 0;
	int unsigned sent = 0;
	// Near the end of the run, neither side idles.
	bit          calm = 1'b0;
	// The next byte is marked as the first byte of a packet.
	logic        next_start = 1'b0;

	dhcp_option_tlv_parser_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sink side. m_tready falls in bursts, and each transaction on the master channel goes
	// to the scoreboard. Values are sampled at the edge before any update of this step.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
			sb.check_summary(m_tdata);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one byte on the slave channel, sometimes after a random gap. The task waits
	// for the transaction and returns at the edge where it completed. s_tvalid therefore
	// stays high into the next byte unless a gap follows.
	task automatic send(input logic [7:0] b, input logic start);
		int unsigned gap;
		if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		sb.note_byte(b, start);
		sent++;
	endtask

	// Sends a byte and marks it as the start of a packet when one was requested.
	task automatic put(input logic [7:0] b);
		send(b, next_start);
		next_start = 1'b0;
		calm = (sent >= 1450);
	endtask

	// Ends the run after a fixed time in case the block hangs. Even the slowest correct
	// run stays far below this limit.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned pkt;
		int unsigned mode;
		int unsigned r;
		int unsigned len;
		int unsigned base;
		int unsigned code;
		int unsigned drain;
		logic [7:0]  tval;

		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first packet has no start marker, so the walk begins from the reset state.
		// It opens with a pad, then a request type and a full address option.
		next_start = 1'b0;
		put(PAD_CODE);
		put(TYPE_CODE); put(8'd1); put(TYPE_REQUEST);
		put(ADDR_CODE); put(8'd4); put(8'hc0); put(8'ha8); put(8'h01); put(8'hff);
		put(END_CODE);
		// These bytes follow the end code and must be ignored.
		put(TYPE_CODE); put(END_CODE);

		// A type option of length zero gives the unknown class.
		next_start = 1'b1;
		put(TYPE_CODE); put(8'd0); put(END_CODE);

		// An empty options area gives the vendor-specific class with a count of zero.
		next_start = 1'b1;
		put(END_CODE);

		// A short address option, a repeated type option, and an end code inside a value.
		next_start = 1'b1;
		put(ADDR_CODE); put(8'd2); put(8'haa); put(8'hbb);
		put(TYPE_CODE); put(8'd1); put(TYPE_OFFER);
		put(8'd7); put(8'd1); put(END_CODE);
		put(TYPE_CODE); put(8'd1); put(TYPE_ACK);
		put(END_CODE);

		// Random packets. Most are well-formed, some are cut short by the next start
		// marker, some are random noise, and a few lack their start marker. Packet eight
		// uses every ordinary code once, which drives the distinct count to 254, its highest reachable value.
		pkt = 0;
		while (sent < 1700 || sb.total_expected < 48) begin
			case ($urandom_range(0, 2))
				0: src_gap_pct = 0;
				1: src_gap_pct = 4;
				default: src_gap_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: sink_stall_pct = 0;
				1: sink_stall_pct = 10;
				default: sink_stall_pct = 40;
			endcase
			if (pkt == 8) begin
				next_start = 1'b1;
				base = $urandom_range(1, 254);
				for (int k = 0; k < 254; k++) begin
					code = ((base - 1 + k) % 254) + 1;
					put(code[7:0]);
					if (code == TYPE_CODE) begin
						put(8'd1); put(TYPE_ACK);
					end else if (code == ADDR_CODE) begin
						put(8'd4);
						repeat (4) put(8'($urandom_range(0, 255)));
					end else begin
						put(8'd0);
					end
				end
				put(END_CODE);
			end else begin
				next_start = ($urandom_range(0, 19) != 0);
				mode = $urandom_range(0, 99);
				if (mode < 6) begin
					repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(0, 7)) begin
						r = $urandom_range(0, 99);
						if (r < 10) begin
							put(PAD_CODE);
						end else if (r < 28) begin
							len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 1;
							case ($urandom_range(0, 5))
								0: tval = TYPE_DISCOVER;
								1: tval = TYPE_OFFER;
								2: tval = TYPE_REQUEST;
								3: tval = TYPE_ACK;
								default: tval = 8'($urandom_range(0, 255));
							endcase
							put(TYPE_CODE);
							put(len[7:0]);
							for (int i = 0; i < len; i++)
								put(i == 0 ? tval : 8'($urandom_range(0, 255)));
						end else if (r < 46) begin
							len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
							put(ADDR_CODE);
							put(len[7:0]);
							repeat (len) put(8'($urandom_range(0, 255)));
						end else begin
							// Long values are rare so that the run stays short.
							len = ($urandom_range(0, 199) == 0) ? $urandom_range(7, 255)
								: $urandom_range(0, 6);
							put(8'($urandom_range(1, 254)));
							put(len[7:0]);
							repeat (len) put(8'($urandom_range(0, 255)));
						end
					end
					if ($urandom_range(0, 99) < 88) begin
						put(END_CODE);
						if ($urandom_range(0, 4) == 0)
							repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
					end
				end
			end
			pkt++;
		end

		// Wait until the last summary has arrived, then keep watching the master channel so
		// that a stray extra transaction would still be caught.
		s_tvalid <= 1'b0;
		drain = 0;
		while (sb.pending() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("summaries never delivered", 32'd0, 32'(sb.pending()));

		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
